@@ rtl/ctbf_pkg.sv @@
package ctbf_pkg;
	localparam int ELEM_W = 64;
	localparam int CFG_AW = 5;
	localparam int CFG_DW = 64;

	typedef enum logic [2:0] {
		OP_GT = 3'd0, OP_LT = 3'd1, OP_GE = 3'd2, OP_LE = 3'd3, OP_EQ = 3'd4, OP_NE = 3'd5
	} cmp_op_t;

	typedef enum logic [1:0] {
		DT_F32 = 2'd0, DT_F64 = 2'd1, DT_I32 = 2'd2, DT_I64 = 2'd3
	} data_type_t;

	localparam logic [CFG_AW-1:0] ADDR_OP  = 5'd0;
	localparam logic [CFG_AW-1:0] ADDR_DT  = 5'd8;
	localparam logic [CFG_AW-1:0] ADDR_THR = 5'd16;

	typedef struct packed {
		logic lt;
		logic eq;
		logic gt;
		logic unord;
	} order_t;
endpackage

@@ rtl/ctbf_if.sv @@
interface ctbf_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] element_bits;
	logic        valid_bit;
	logic        last_element;
	modport source (output valid, element_bits, valid_bit, last_element, input ready);
	modport sink (input valid, element_bits, valid_bit, last_element, output ready);
endinterface

interface ctbf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] mask_byte;
	logic       last_byte;
	modport source (output valid, mask_byte, last_byte, input ready);
	modport sink (input valid, mask_byte, last_byte, output ready);
endinterface

@@ rtl/ctbf_compare.sv @@
module ctbf_compare (
	input  logic [63:0] a,
	input  logic [63:0] b,
	input  logic [1:0]  dtype,
	output ctbf_pkg::order_t ord
);
	import ctbf_pkg::*;

	logic        sa, sb, na, nb, za, zb, wide, is_int;
	logic [62:0] ma, mb;
	logic        mag_lt, mag_eq, ilt;

	always_comb begin
		wide   = (dtype == DT_F64) || (dtype == DT_I64);
		is_int = (dtype == DT_I32) || (dtype == DT_I64);
		if (wide) begin
			sa = a[63];
			sb = b[63];
			ma = a[62:0];
			mb = b[62:0];
			na = (a[62:52] == 11'h7ff) && (a[51:0] != '0);
			nb = (b[62:52] == 11'h7ff) && (b[51:0] != '0);
		end else begin
			sa = a[31];
			sb = b[31];
			ma = {32'd0, a[30:0]};
			mb = {32'd0, b[30:0]};
			na = (a[30:23] == 8'hff) && (a[22:0] != '0);
			nb = (b[30:23] == 8'hff) && (b[22:0] != '0);
		end
		za     = (ma == '0);
		zb     = (mb == '0);
		mag_lt = ma < mb;
		mag_eq = ma == mb;
		// two's complement: sign decides, else magnitude bits order directly
		ilt    = (sa != sb) ? sa : mag_lt;
		if (is_int) begin
			ord.eq    = (sa == sb) && mag_eq;
			ord.lt    = ilt;
			ord.gt    = !ilt && !ord.eq;
			ord.unord = 1'b0;
		end else begin
			ord.unord = na || nb;
			if (za && zb) begin
				ord.eq = 1'b1;
				ord.lt = 1'b0;
			end else if (sa != sb) begin
				ord.eq = 1'b0;
				ord.lt = sa;
			end else begin
				ord.eq = mag_eq;
				ord.lt = sa ? (!mag_lt && !mag_eq) : mag_lt;
			end
			ord.gt = !ord.lt && !ord.eq;
		end
	end
endmodule

@@ rtl/column_threshold_bitmap_filter.sv @@
// column threshold bitmap filter
// in: one column element per item (element_bits, valid_bit, last_element)
// out: packed match bytes, element order lsb first, last_byte on the final byte
// configure compare_op (0x0), data_type (0x8) and threshold (0x10) over apb
// while idle; 64-bit data, pready always high, reads return the register.
// each element is compared against the threshold combinationally and its bit
// joins a partial byte; every eighth element or the last one emits a byte
// through the output register, valid in the cycle after the closing element.
// throughput is one element per cycle while in_ch.ready is high.
// the input is accepted while a byte waits, unless that waiting byte is
// stalled and the incoming element would close another byte.
// reset clears config, out valid, the partial byte and the bit position.
module column_threshold_bitmap_filter (
	input  logic                          clk,
	input  logic                          arst_n,
	ctbf_in_if.sink                       in_ch,
	ctbf_out_if.source                    out_ch,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ctbf_pkg::CFG_AW-1:0]   paddr,
	input  logic [ctbf_pkg::CFG_DW-1:0]   pwdata,
	output logic [ctbf_pkg::CFG_DW-1:0]   prdata,
	output logic                          pready
);
	import ctbf_pkg::*;

	logic [2:0]  op_q;
	logic [1:0]  dt_q;
	logic [63:0] thr_q;
	logic [7:0]  partial_q;
	logic [2:0]  pos_q;
	logic        ovalid_q;
	logic [7:0]  obyte_q;
	logic        olast_q;
	order_t      ord;
	logic        hit, rel, closes, acc, wr;
	logic [7:0]  next_byte;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q  <= '0;
			dt_q  <= '0;
			thr_q <= '0;
		end else if (wr) begin
			unique case (paddr)
				ADDR_OP:  op_q  <= pwdata[2:0];
				ADDR_DT:  dt_q  <= pwdata[1:0];
				ADDR_THR: thr_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			ADDR_OP:  prdata = {61'd0, op_q};
			ADDR_DT:  prdata = {62'd0, dt_q};
			ADDR_THR: prdata = thr_q;
			default:  prdata = '0;
		endcase
	end

	ctbf_compare u_cmp (.a(in_ch.element_bits), .b(thr_q), .dtype(dt_q), .ord(ord));

	always_comb begin
		unique case (op_q)
			OP_GT:   rel = ord.gt;
			OP_LT:   rel = ord.lt;
			OP_GE:   rel = ord.gt || ord.eq;
			OP_LE:   rel = ord.lt || ord.eq;
			OP_EQ:   rel = ord.eq;
			OP_NE:   rel = !ord.eq;
			default: rel = 1'b0;
		endcase
		hit       = rel && !ord.unord && in_ch.valid_bit;
		next_byte = partial_q | (hit ? (8'd1 << pos_q) : 8'd0);
		closes    = (pos_q == 3'd7) || in_ch.last_element;
	end

	assign in_ch.ready = !ovalid_q || out_ch.ready || !closes;
	assign acc         = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			pos_q     <= '0;
			ovalid_q  <= 1'b0;
		end else begin
			if (out_ch.ready) ovalid_q <= 1'b0;
			if (acc) begin
				if (closes) begin
					partial_q <= '0;
					pos_q     <= '0;
					ovalid_q  <= 1'b1;
				end else begin
					partial_q <= next_byte;
					pos_q     <= pos_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && closes) begin
			obyte_q <= next_byte;
			olast_q <= in_ch.last_element;
		end
	end

	assign out_ch.valid     = ovalid_q;
	assign out_ch.mask_byte = obyte_q;
	assign out_ch.last_byte = olast_q;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.mask_byte))
		else $error("stalled byte changed");
	a_pos_clear: assert property (@(posedge clk) disable iff (!arst_n)
		acc && closes |=> pos_q == 3'd0 && partial_q == 8'd0)
		else $error("byte state not cleared");
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		ovalid_q && !out_ch.ready && closes |-> !in_ch.ready)
		else $error("byte overwritten");
endmodule
